[sv/csi_pkg.sv]
// Shared types, register codes and the step table, indexed by subdivision count, for the spline interpolator.
package csi_pkg;

	localparam int TAU_W = 17;
	localparam int SUB_W = 6;
	localparam int T_W   = 16;
	localparam logic [TAU_W-1:0] TAU_ONE = 17'd65536;

	typedef enum logic [1:0] {
		REG_TENSION  = 2'd0,
		REG_SUBDIV   = 2'd1,
		REG_EXTEND   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_COEF,
		S_RUN,
		S_WAIT
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
	} tctl_t;

	typedef struct packed {
		logic lor;
		logic eoc;
	} ptag_t;

	typedef struct packed {
		logic [T_W-1:0] tq;
		logic [T_W-1:0] t2;
		logic [T_W-1:0] t3;
	} tvals_t;

	// 2^16 / s split into quotient and remainder, s = 1..63
	typedef struct packed {
		logic [16:0]      q;
		logic [SUB_W-1:0] r;
	} rcp_t;

	typedef rcp_t [63:0] rcp_tab_t;

	// restoring long division of 2^16 by each s
	function automatic rcp_tab_t rcp_build();
		rcp_tab_t       tab;
		logic [16:0]    num;
		logic [SUB_W:0] acc;
		tab[0] = '0;
		num = 17'h10000;
		for (int k = 1; k < 64; k++) begin
			acc = '0;
			for (int b = 16; b >= 0; b--) begin
				acc = {acc[SUB_W-1:0], num[b]};
				tab[k].q[b] = (acc >= 7'(k));
				if (tab[k].q[b]) acc = acc - 7'(k);
			end
			tab[k].r = acc[SUB_W-1:0];
		end
		return tab;
	endfunction

	localparam rcp_tab_t RCP = rcp_build();

endpackage

[sv/cardinal_spline_interpolator.sv]
// Cardinal spline interpolator top level: control point window, sequencer, lanes and merge.
// Each control point word is taken only when the evaluation pipeline is empty. A point that
// completes a segment is followed by coefficient setup in S_DIFF and S_COEF, then S_RUN, in
// which the shared t generator issues one output point per cycle unless the output stalls,
// subdivisions points in all (8 by default), then the pipeline drains; a last point with end
// extension adds a closing segment, run once the one before it has drained. A word that
// completes no segment is taken every cycle while the pipeline is empty. Output
// stalls hold the whole pipeline in place; x, y and z are computed in three parallel lanes
// and saturated to the signed coordinate range.
module cardinal_spline_interpolator #(
	parameter int COORD_WIDTH      = 32,
	parameter int MAX_SUBDIVISIONS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [csi_pkg::TAU_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] in_x,
	input  logic signed [COORD_WIDTH-1:0] in_y,
	input  logic signed [COORD_WIDTH-1:0] in_z,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          last_of_run,
	output logic                          end_of_curve
);
	import csi_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic [TAU_W-1:0] tau_q, tau_eff;
	logic [SUB_W-1:0] sub_q, sub_eff;
	logic             ext_q;

	logic signed [CW-1:0] win_q  [3][3];
	logic signed [CW-1:0] nwin   [3][3];
	logic signed [CW-1:0] pin    [3];
	logic signed [CW-1:0] seg1   [4][3];
	logic signed [CW-1:0] seg2   [4][3];
	logic signed [CW-1:0] cur_q  [4][3];
	logic signed [CW-1:0] pend_q [4][3];
	logic signed [CW-1:0] res    [3];
	logic [1:0]           ps_q, nps;
	logic                 has1, has2, pend_v_q, last_q;

	state_t  state_q, state_d;
	tctl_t   tctl;
	ptag_t   tag;
	tvals_t  t_s3;
	ptag_t   tag_s3;
	logic    v_s3, last_issue, tg_busy, mg_busy, busy, adv;
	logic    load_diff, load_coef, accept;

	function automatic logic signed [CW-1:0] ghost(logic signed [CW-1:0] e,
			logic signed [CW-1:0] n);
		logic signed [CW+1:0] v;
		v = $signed({e[CW-1], e, 1'b0}) - $signed({{2{n[CW-1]}}, n});
		if (&v[CW+1:CW-1] || ~|v[CW+1:CW-1]) begin
			return v[CW-1:0];
		end
		return {v[CW+1], {(CW-1){~v[CW+1]}}};
	endfunction

	assign tau_eff = (tau_q > TAU_ONE) ? TAU_ONE : tau_q;
	always_comb begin
		if (sub_q == '0) begin
			sub_eff = 6'd1;
		end else if ({1'b0, sub_q} > 7'(MAX_SUBDIVISIONS)) begin
			sub_eff = 6'(MAX_SUBDIVISIONS);
		end else begin
			sub_eff = sub_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= 17'd32768;
			sub_q <= 6'd8;
			ext_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TENSION: tau_q <= cfg_data;
				REG_SUBDIV:  sub_q <= cfg_data[SUB_W-1:0];
				REG_EXTEND:  ext_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pin[0] = in_x;
	assign pin[1] = in_y;
	assign pin[2] = in_z;

	// window update and segments caused by this word
	always_comb begin
		nwin = win_q;
		nps  = ps_q;
		has1 = 1'b0;
		has2 = 1'b0;
		seg1 = '{default: '0};
		seg2 = '{default: '0};
		if (ps_q == 2'd3) begin
			seg1[0] = win_q[0];
			seg1[1] = win_q[1];
			seg1[2] = win_q[2];
			seg1[3] = pin;
			nwin[0] = win_q[1];
			nwin[1] = win_q[2];
			nwin[2] = pin;
			has1    = 1'b1;
		end else if (ps_q == 2'd1 && ext_q) begin
			for (int a = 0; a < 3; a++) begin
				nwin[0][a] = ghost(win_q[0][a], pin[a]);
			end
			nwin[1] = win_q[0];
			nwin[2] = pin;
			nps     = 2'd3;
		end else begin
			nwin[ps_q] = pin;
			nps        = ps_q + 2'd1;
		end
		if (last_point && ext_q && nps == 2'd3) begin
			seg2[0] = nwin[0];
			seg2[1] = nwin[1];
			seg2[2] = nwin[2];
			for (int a = 0; a < 3; a++) begin
				seg2[3][a] = ghost(nwin[2][a], nwin[1][a]);
			end
			has2 = 1'b1;
		end
	end

	assign busy   = tg_busy || mg_busy;
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		load_diff = 1'b0;
		load_coef = 1'b0;
		tctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !busy;
				if (in_valid && !busy && (has1 || has2)) begin
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				load_diff = 1'b1;
				state_d   = S_COEF;
			end
			S_COEF: begin
				load_coef  = 1'b1;
				tctl.start = 1'b1;
				state_d    = S_RUN;
			end
			S_RUN: begin
				tctl.issue = adv;
				if (adv && last_issue) begin
					state_d = pend_v_q ? S_WAIT : S_IDLE;
				end
			end
			S_WAIT: begin
				if (!busy) begin
					state_d = S_DIFF;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign tag.lor = last_issue && !pend_v_q;
	assign tag.eoc = last_issue && !pend_v_q && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ps_q     <= '0;
			pend_v_q <= 1'b0;
			last_q   <= 1'b0;
			win_q    <= '{default: '0};
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q   <= last_point;
				pend_v_q <= has1 && has2;
				if (last_point) begin
					win_q <= '{default: '0};
					ps_q  <= '0;
				end else begin
					win_q <= nwin;
					ps_q  <= nps;
				end
			end else if (state_q == S_WAIT && !busy) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (has1) begin
				cur_q <= seg1;
			end else begin
				cur_q <= seg2;
			end
			pend_q <= seg2;
		end else if (state_q == S_WAIT && !busy) begin
			cur_q <= pend_q;
		end
	end

	csi_tgen u_tgen (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl        (tctl),
		.sub_eff    (sub_eff),
		.tag        (tag),
		.t_s3       (t_s3),
		.v_s3       (v_s3),
		.tag_s3     (tag_s3),
		.last_issue (last_issue),
		.busy       (tg_busy)
	);

	for (genvar a = 0; a < 3; a++) begin : g_lane
		csi_lane #(.CW(CW)) u_lane (
			.clk       (clk),
			.adv       (adv),
			.load_diff (load_diff),
			.load_coef (load_coef),
			.tau       (tau_eff),
			.q0        (cur_q[0][a]),
			.q1        (cur_q[1][a]),
			.q2        (cur_q[2][a]),
			.q3        (cur_q[3][a]),
			.t         (t_s3),
			.res       (res[a])
		);
	end

	csi_merge #(.CW(CW)) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s3         (v_s3),
		.tag_s3       (tag_s3),
		.res          (res),
		.out_ready    (out_ready),
		.adv          (adv),
		.busy         (mg_busy),
		.out_valid    (out_valid),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.last_of_run  (last_of_run),
		.end_of_curve (end_of_curve)
	);

	a_coef_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_diff |-> !busy)
		else $error("coefficient load while points in flight");

	a_eoc_lor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_curve |-> last_of_run)
		else $error("end of curve without end of run");

	a_wait_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WAIT |-> pend_v_q)
		else $error("waiting with no pending segment");

endmodule

[sv/csi_tgen.sv]
// Segment parameter generator: steps t = i/s and pipelines t^2 and t^3.
module csi_tgen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  csi_pkg::tctl_t                ctl,
	input  logic [csi_pkg::SUB_W-1:0]     sub_eff,
	input  csi_pkg::ptag_t                tag,
	output csi_pkg::tvals_t               t_s3,
	output logic                          v_s3,
	output csi_pkg::ptag_t                tag_s3,
	output logic                          last_issue,
	output logic                          busy
);
	import csi_pkg::*;

	logic [SUB_W-1:0] i_q;
	logic [16:0]      tq_q;
	logic [SUB_W-1:0] rem_q;
	rcp_t             rcp;
	logic [SUB_W:0]   rem_sum;
	logic             carry;

	logic             v_s1, v_s2;
	ptag_t            tag_s1, tag_s2;
	logic [T_W-1:0]   tq_s1, tq_s2, t2_s2;
	logic [2*T_W-1:0] sq, cu;

	assign rcp        = RCP[sub_eff];
	assign rem_sum    = {1'b0, rem_q} + {1'b0, rcp.r};
	assign carry      = rem_sum >= {1'b0, sub_eff};
	assign last_issue = i_q == sub_eff - 6'd1;
	assign busy       = v_s1 | v_s2 | v_s3;

	assign sq = tq_s1 * tq_s1 + 32'd32768;
	assign cu = t2_s2 * tq_s2 + 32'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			tq_q  <= '0;
			rem_q <= '0;
		end else if (ctl.start) begin
			i_q   <= '0;
			tq_q  <= '0;
			rem_q <= '0;
		end else if (ctl.issue) begin
			i_q   <= i_q + 6'd1;
			tq_q  <= tq_q + rcp.q + {16'd0, carry};
			rem_q <= carry ? SUB_W'(rem_sum - {1'b0, sub_eff}) : rem_sum[SUB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tq_s1     <= tq_q[T_W-1:0];
			tag_s1    <= tag;
			tq_s2     <= tq_s1;
			t2_s2     <= sq[2*T_W-1:T_W];
			tag_s2    <= tag_s1;
			t_s3.tq   <= tq_s2;
			t_s3.t2   <= t2_s2;
			t_s3.t3   <= cu[2*T_W-1:T_W];
			tag_s3    <= tag_s2;
		end
	end

endmodule

[sv/csi_lane.sv]
// One coordinate lane: segment coefficients and the cubic evaluated per point.
module csi_lane #(
	parameter int CW = 32
) (
	input  logic                        clk,
	input  logic                        adv,
	input  logic                        load_diff,
	input  logic                        load_coef,
	input  logic [csi_pkg::TAU_W-1:0]   tau,
	input  logic signed [CW-1:0]        q0,
	input  logic signed [CW-1:0]        q1,
	input  logic signed [CW-1:0]        q2,
	input  logic signed [CW-1:0]        q3,
	input  csi_pkg::tvals_t             t,
	output logic signed [CW-1:0]        res
);
	import csi_pkg::*;

	localparam int DW = CW + 3;
	localparam int PW = DW + 18;
	localparam int CF = CW + 6;
	localparam int MW = CF + 17;
	localparam int SW = CF + 3;
	localparam logic signed [PW-1:0] HALF_P = PW'(32768);
	localparam logic signed [MW-1:0] HALF_M = MW'(32768);

	logic signed [DW-1:0] x0, x1, x2, x3;
	logic signed [DW-1:0] d1_q, d2_q, d3_q, e2_q, e3_q;
	logic signed [CW-1:0] p1_q;
	logic signed [17:0]   tau_s;
	logic signed [PW-1:0] pa, pb, pc;
	logic signed [CF-1:0] c1_q, c2_q, c3_q;
	logic signed [MW-1:0] ma, mb, mc;
	logic signed [CF:0]   m1_s4, m2_s4, m3_s4;
	logic signed [SW-1:0] sum;

	assign x0 = DW'(q0);
	assign x1 = DW'(q1);
	assign x2 = DW'(q2);
	assign x3 = DW'(q3);

	assign tau_s = $signed({1'b0, tau});
	assign pa = PW'(d1_q) * PW'(tau_s) + HALF_P;
	assign pb = PW'(d2_q) * PW'(tau_s) + HALF_P;
	assign pc = PW'(d3_q) * PW'(tau_s) + HALF_P;

	assign ma = MW'(c1_q) * MW'($signed({1'b0, t.tq})) + HALF_M;
	assign mb = MW'(c2_q) * MW'($signed({1'b0, t.t2})) + HALF_M;
	assign mc = MW'(c3_q) * MW'($signed({1'b0, t.t3})) + HALF_M;

	assign sum = SW'(p1_q) + SW'(m1_s4) + SW'(m2_s4) + SW'(m3_s4);

	always_comb begin
		if (&sum[SW-1:CW-1] || ~|sum[SW-1:CW-1]) begin
			res = sum[CW-1:0];
		end else begin
			res = {sum[SW-1], {(CW-1){~sum[SW-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (load_diff) begin
			d1_q <= x2 - x0;
			d2_q <= (x0 <<< 1) + x1 - (x2 <<< 1) - x3;
			d3_q <= x2 + x3 - x0 - x1;
			e2_q <= (x2 - x1) + ((x2 - x1) <<< 1);
			e3_q <= (x1 - x2) <<< 1;
			p1_q <= q1;
		end
		if (load_coef) begin
			c1_q <= CF'($signed(pa[PW-1:16]));
			c2_q <= CF'($signed(pb[PW-1:16])) + CF'(e2_q);
			c3_q <= CF'($signed(pc[PW-1:16])) + CF'(e3_q);
		end
		if (adv) begin
			m1_s4 <= $signed(ma[MW-1:16]);
			m2_s4 <= $signed(mb[MW-1:16]);
			m3_s4 <= $signed(mc[MW-1:16]);
		end
	end

endmodule

[sv/csi_merge.sv]
// Merge stage: joins the three lane results and tags into the output register.
module csi_merge #(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_s3,
	input  csi_pkg::ptag_t       tag_s3,
	input  logic signed [CW-1:0] res [3],
	input  logic                 out_ready,
	output logic                 adv,
	output logic                 busy,
	output logic                 out_valid,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [CW-1:0] out_z,
	output logic                 last_of_run,
	output logic                 end_of_curve
);
	import csi_pkg::*;

	logic  v_s4;
	ptag_t tag_s4;

	assign adv  = !out_valid || out_ready;
	assign busy = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4 <= tag_s3;
			if (v_s4) begin
				out_x        <= res[0];
				out_y        <= res[1];
				out_z        <= res[2];
				last_of_run  <= tag_s4.lor;
				end_of_curve <= tag_s4.eoc;
			end
		end
	end

endmodule
